/* hdl/pst_pkg.sv */
// Package for the prime sieve table: sizes, request codes and the map port request.
// Used by every module of the block except the generic RAM.
package pst_pkg;
	localparam int SIEVE_SIZE = 8192;
	localparam int ROOT_LIMIT = 90;
	localparam int NUM_W = 13;
	localparam int TDATA_W = 16;
	localparam int AW = $clog2(SIEVE_SIZE);
	localparam int CW = AW + 2;
	localparam int BASE_LAST = (ROOT_LIMIT < SIEVE_SIZE) ? ROOT_LIMIT : SIEVE_SIZE - 1;
	localparam int BW = $clog2(BASE_LAST + 1);

	localparam logic REQ_BUILD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic          wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_req_t;
endpackage

/* hdl/pst_map_ram.sv */
// Generic single-bit-wide RAM with one write port and one registered read port.
// No dependencies.
module pst_map_ram #(
	parameter int AW = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);
	logic mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hdl/pst_ctrl.sv */
// Sequencer of the prime sieve table: query handling, sieve build walk with one
// shared adder, and the output register. Depends on pst_pkg.
module pst_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_req_type,
	input  logic [pst_pkg::NUM_W-1:0] in_number,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [pst_pkg::NUM_W-1:0] out_prime_value,
	output logic                 out_is_prime,
	output pst_pkg::mem_req_t    mem_req,
	input  logic                 mem_rdata
);
	import pst_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QRES,
		ST_FILL,
		ST_BRD,
		ST_BCHK,
		ST_MARK,
		ST_BDONE
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic [BW-1:0]     base_q;
	logic [NUM_W-1:0]  num_q;
	logic              built_q;
	logic              out_valid_q;
	logic [NUM_W-1:0]  out_value_q;
	logic              out_prime_q;
	logic [CW-1:0]     add_a;
	logic [CW-1:0]     sum;
	logic              slot_free;
	logic              load_out;
	logic              accept;
	logic              query_hit;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = ((state_q == ST_QRES) || (state_q == ST_BDONE)) && slot_free;
	assign add_a     = (state_q == ST_MARK) ? cnt_q : CW'(base_q);
	assign sum       = add_a + CW'(base_q);
	assign query_hit = built_q && mem_rdata && (32'(num_q) < SIEVE_SIZE);

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				mem_req.re    = accept;
				mem_req.raddr = AW'(in_number);
			end
			ST_FILL: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cnt_q[AW-1:0];
				mem_req.wdata = (cnt_q >= CW'(2));
			end
			ST_BRD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = AW'(base_q);
			end
			ST_MARK: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cnt_q[AW-1:0];
				mem_req.wdata = 1'b0;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_prime_q <= 1'b0;
			num_q       <= '0;
			cnt_q       <= '0;
			base_q      <= '0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						num_q <= in_number;
						if (in_req_type == REQ_QUERY) begin
							state_q <= ST_QRES;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_FILL;
						end
					end
				end
				ST_QRES: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= query_hit ? num_q : '0;
						out_prime_q <= query_hit;
						state_q     <= ST_IDLE;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(SIEVE_SIZE - 1)) begin
						base_q  <= BW'(2);
						state_q <= ST_BRD;
					end
				end
				ST_BRD: begin
					state_q <= ST_BCHK;
				end
				ST_BCHK: begin
					if (mem_rdata && (sum < CW'(SIEVE_SIZE))) begin
						cnt_q   <= sum;
						state_q <= ST_MARK;
					end else if (base_q == BW'(BASE_LAST)) begin
						state_q <= ST_BDONE;
					end else begin
						base_q  <= base_q + BW'(1);
						state_q <= ST_BRD;
					end
				end
				ST_MARK: begin
					cnt_q <= sum;
					if (sum >= CW'(SIEVE_SIZE)) begin
						if (base_q == BW'(BASE_LAST)) begin
							state_q <= ST_BDONE;
						end else begin
							base_q  <= base_q + BW'(1);
							state_q <= ST_BRD;
						end
					end
				end
				ST_BDONE: begin
					built_q <= 1'b1;
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= '0;
						out_prime_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign out_prime_value = out_value_q;
	assign out_is_prime    = out_prime_q;
endmodule

/* hdl/prime_sieve_table_top.sv */
// Top level of the prime sieve table: stream ports, map RAM and sequencer.
// Depends on pst_pkg, pst_map_ram and pst_ctrl.
//
// The block keeps a one-bit primality map for the numbers 0 to SIEVE_SIZE-1.
// An input item on the s_ channel is either a build request (tuser low) or a
// query (tuser high) for the number in tdata. Every item gives exactly one
// result item on the m_ channel: for a query, the number in tdata and tuser
// high if it is prime, otherwise zero and tuser low; for a build, zero.
// A query reads the map RAM on acceptance and loads the result register from
// the registered read in ST_QRES; a new item is taken only once the result is
// loaded.
// A build first writes all SIEVE_SIZE entries, one per cycle, then reads each
// base from 2 to ROOT_LIMIT in ST_BRD and ST_BCHK, and clears each multiple
// of a prime base in ST_MARK through the shared adder.
// The input is not ready while an item is at work.
// After reset the map counts as empty, so queries report not prime until the
// first build completes. When the receiver stalls, the result stays in the
// output register and the block takes one more item, which waits for the
// register to free before its own result is loaded.
module prime_sieve_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [12:0] number, [15:13] zero
	input  logic        s_tuser,  // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [12:0] prime_value, [15:13] zero
	output logic        m_tuser   // [0] is_prime
);
	import pst_pkg::*;

	mem_req_t         mem_req;
	logic             mem_rdata;
	logic [NUM_W-1:0] prime_value;

	pst_map_ram #(
		.AW(AW)
	) u_map (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	pst_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_req_type     (s_tuser),
		.in_number       (s_tdata[NUM_W-1:0]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_prime_value (prime_value),
		.out_is_prime    (m_tuser),
		.mem_req         (mem_req),
		.mem_rdata       (mem_rdata)
	);

	assign m_tdata = TDATA_W'(prime_value);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on two consecutive cycles");

	a_prime_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[12:0] > 13'd1))
		else $error("prime flag with a value below two");

	a_not_prime_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == 16'd0))
		else $error("nonzero value without prime flag");

	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mem_req.we)
		else $error("map written while the block is idle");
endmodule
